FILE: hw/rtl/ptt_pkg.sv
`default_nettype none

package ptt_pkg;

  // table size and field widths
  localparam int TIMER_COUNT = 16;
  localparam int IDX_W       = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
  localparam int ID_W        = 4;
  localparam int TICK_W      = 32;

  // command queue between front and back
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  // input op codes
  localparam logic [1:0] OP_SET    = 2'd0;
  localparam logic [1:0] OP_KILL   = 2'd1;
  localparam logic [1:0] OP_UPDATE = 2'd2;

  typedef enum logic [1:0] {
    CMD_SET,
    CMD_KILL,
    CMD_UPDATE
  } cmd_kind_t;

  // classified command as held in the queue
  typedef struct packed {
    cmd_kind_t          kind;
    logic [IDX_W-1:0]   idx;
    logic [TICK_W-1:0]  period;
    logic [TICK_W-1:0]  now;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_EVAL,
    BK_FLUSH
  } bk_state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/ptt_ram.sv
`default_nettype none

module ptt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/ptt_front.sv
`default_nettype none

module ptt_front (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [1:0]            in_op,
  input  wire logic [ptt_pkg::ID_W-1:0]   in_timer_id,
  input  wire logic [ptt_pkg::TICK_W-1:0] in_period,
  input  wire logic [ptt_pkg::TICK_W-1:0] in_now,
  output logic                       q_valid,
  output ptt_pkg::cmd_t              q_cmd,
  input  wire logic                  q_pop
);

  import ptt_pkg::*;

  cmd_t              q_mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic [QCNT_W-1:0] count_nxt;
  cmd_t              cmd;
  logic              keep;
  logic              id_ok;
  logic              push;

  // classify the incoming transaction, dropping ones with no effect
  assign id_ok = (32'(in_timer_id) < TIMER_COUNT);

  always_comb begin
    cmd.idx    = IDX_W'(in_timer_id);
    cmd.period = in_period;
    cmd.now    = in_now;
    cmd.kind   = CMD_UPDATE;
    keep       = 1'b0;
    unique case (in_op)
      OP_SET: begin
        cmd.kind = CMD_SET;
        keep     = id_ok;
      end
      OP_KILL: begin
        cmd.kind = CMD_KILL;
        keep     = id_ok;
      end
      OP_UPDATE: begin
        cmd.kind = CMD_UPDATE;
        keep     = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign in_ready = (count_r != QCNT_W'(QDEPTH));
  assign push     = in_valid && in_ready && keep;
  assign q_valid  = (count_r != '0);
  assign q_cmd    = q_mem_r[rd_ptr_r];

  // occupancy
  always_comb begin
    count_nxt = count_r;
    if (push && !q_pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (!push && q_pop) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (q_pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= cmd;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/ptt_back.sv
`default_nettype none

module ptt_back (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  q_valid,
  input  wire ptt_pkg::cmd_t         q_cmd,
  output logic                       q_pop,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [ptt_pkg::ID_W-1:0]   out_fired_id,
  output logic                       out_last_of_run
);

  import ptt_pkg::*;

  bk_state_t          state_r;
  bk_state_t          state_nxt;
  logic               armed_r [TIMER_COUNT];
  logic [IDX_W-1:0]   scan_idx_r;
  logic [TICK_W-1:0]  now_r;
  logic               pend_valid_r;
  logic [IDX_W-1:0]   pend_id_r;
  logic               out_valid_r;
  logic [ID_W-1:0]    out_id_r;
  logic               out_last_r;

  // ram ports
  logic               iv_we;
  logic               st_we;
  logic [IDX_W-1:0]   st_waddr;
  logic [TICK_W-1:0]  st_wdata;
  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  logic [TICK_W-1:0]  iv_rdata;
  logic [TICK_W-1:0]  st_rdata;

  // per-cycle controls
  logic               arm_set;
  logic               arm_clr;
  logic               load_now;
  logic               scan_inc;
  logic               pend_load;
  logic               pend_clr;
  logic               emit;
  logic               emit_last;

  logic [TICK_W-1:0]  elapsed;
  logic               due;
  logic               out_free;
  logic               last_idx;
  logic               eval_stall;

  ptt_ram #(.WIDTH(TICK_W), .DEPTH(TIMER_COUNT)) u_interval_ram (
    .clk   (clk),
    .we    (iv_we),
    .waddr (q_cmd.idx),
    .wdata (q_cmd.period),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (iv_rdata)
  );

  ptt_ram #(.WIDTH(TICK_W), .DEPTH(TIMER_COUNT)) u_start_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (st_rdata)
  );

  // expiry test on the entry under the scan pointer
  assign elapsed    = now_r - st_rdata;
  assign due        = armed_r[scan_idx_r] && (iv_rdata <= elapsed);
  assign out_free   = !out_valid_r || out_ready;
  assign last_idx   = (scan_idx_r == IDX_W'(TIMER_COUNT - 1));
  assign eval_stall = due && pend_valid_r && !out_free;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (q_valid && (q_cmd.kind == CMD_UPDATE)) begin
          state_nxt = BK_READ;
        end
      end
      BK_READ: begin
        state_nxt = BK_EVAL;
      end
      BK_EVAL: begin
        if (!eval_stall && last_idx) begin
          state_nxt = BK_FLUSH;
        end
      end
      BK_FLUSH: begin
        if (!pend_valid_r || out_free) begin
          state_nxt = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  // state outputs
  always_comb begin
    q_pop     = 1'b0;
    iv_we     = 1'b0;
    st_we     = 1'b0;
    st_waddr  = q_cmd.idx;
    st_wdata  = q_cmd.now;
    rd_en     = 1'b0;
    rd_addr   = scan_idx_r;
    arm_set   = 1'b0;
    arm_clr   = 1'b0;
    load_now  = 1'b0;
    scan_inc  = 1'b0;
    pend_load = 1'b0;
    pend_clr  = 1'b0;
    emit      = 1'b0;
    emit_last = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          unique case (q_cmd.kind)
            CMD_SET: begin
              iv_we   = 1'b1;
              st_we   = 1'b1;
              arm_set = 1'b1;
            end
            CMD_KILL: begin
              arm_clr = 1'b1;
            end
            CMD_UPDATE: begin
              load_now = 1'b1;
            end
            default: begin
              q_pop = 1'b1;
            end
          endcase
        end
      end
      BK_READ: begin
        rd_en = 1'b1;
      end
      BK_EVAL: begin
        if (!eval_stall) begin
          if (due) begin
            st_we     = 1'b1;
            st_waddr  = scan_idx_r;
            st_wdata  = st_rdata + iv_rdata;
            pend_load = 1'b1;
            emit      = pend_valid_r;
          end
          if (!last_idx) begin
            scan_inc = 1'b1;
            rd_en    = 1'b1;
            rd_addr  = scan_idx_r + IDX_W'(1);
          end
        end
      end
      BK_FLUSH: begin
        if (pend_valid_r && out_free) begin
          emit      = 1'b1;
          emit_last = 1'b1;
          pend_clr  = 1'b1;
        end
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= BK_IDLE;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      scan_idx_r   <= '0;
      for (int i = 0; i < TIMER_COUNT; i++) begin
        armed_r[i] <= 1'b0;
      end
    end else begin
      state_r <= state_nxt;
      if (arm_set) begin
        armed_r[q_cmd.idx] <= 1'b1;
      end else if (arm_clr) begin
        armed_r[q_cmd.idx] <= 1'b0;
      end
      if (load_now) begin
        scan_idx_r <= '0;
      end else if (scan_inc) begin
        scan_idx_r <= scan_idx_r + IDX_W'(1);
      end
      if (pend_load) begin
        pend_valid_r <= 1'b1;
      end else if (pend_clr) begin
        pend_valid_r <= 1'b0;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (load_now) begin
      now_r <= q_cmd.now;
    end
    if (pend_load) begin
      pend_id_r <= scan_idx_r;
    end
    if (emit) begin
      out_id_r   <= ID_W'(pend_id_r);
      out_last_r <= emit_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_fired_id    = out_id_r;
  assign out_last_of_run = out_last_r;

endmodule

`default_nettype wire

FILE: hw/rtl/periodic_timer_table.sv
// Periodic timer table with TIMER_COUNT entries. A set transaction arms an entry
// with a period and the given tick as its start; a kill transaction disarms it;
// an update transaction carries the current tick and returns, in ascending id
// order, one result per armed entry whose period is at most the elapsed ticks
// (modulo 2^32), the last of them flagged with out_last_of_run. A fired entry's
// start advances by exactly one period. Commands first pass a two-deep queue,
// so new transactions are taken while an update is still scanning. Set and kill
// are done in the dequeue step of the execution stage. An update steps through
// dequeue, first read, one compare per entry and a final flush, and can wait
// while the result channel is held back: the scan reads one entry a cycle, save
// when so stalled, from the period and start RAMs through their single read port.
// Set, kill and op code 3 produce no results; a set or kill with a bad id is dropped.
`default_nettype none

module periodic_timer_table (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [1:0]             in_op,
  input  wire logic [ptt_pkg::ID_W-1:0]   in_timer_id,
  input  wire logic [ptt_pkg::TICK_W-1:0] in_period,
  input  wire logic [ptt_pkg::TICK_W-1:0] in_now,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [ptt_pkg::ID_W-1:0]    out_fired_id,
  output logic                        out_last_of_run
);

  import ptt_pkg::*;

  logic q_valid;
  cmd_t q_cmd;
  logic q_pop;

  // accept and classify transactions
  ptt_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_op       (in_op),
    .in_timer_id (in_timer_id),
    .in_period   (in_period),
    .in_now      (in_now),
    .q_valid     (q_valid),
    .q_cmd       (q_cmd),
    .q_pop       (q_pop)
  );

  // execute commands and scan the table
  ptt_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_cmd           (q_cmd),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_fired_id    (out_fired_id),
    .out_last_of_run (out_last_of_run)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/ptt_checker.sv
`default_nettype none

module ptt_checker (
  input wire logic                      clk,
  input wire logic                      rst_n,
  input wire logic                      in_ready,
  input wire logic                      out_valid,
  input wire logic                      out_ready,
  input wire logic [ptt_pkg::ID_W-1:0]  out_fired_id,
  input wire logic                      out_last_of_run
);

  import ptt_pkg::*;

  logic            in_run_r;
  logic [ID_W-1:0] prev_id_r;

  // track the open run of fired ids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_run_r <= 1'b0;
    end else if (out_valid && out_ready) begin
      in_run_r <= !out_last_of_run;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && out_ready) begin
      prev_id_r <= out_fired_id;
    end
  end

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_fired_id)
      && $stable(out_last_of_run))
    else $error("result changed while stalled");

  // ids within one run strictly ascend
  a_ascending: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && in_run_r |-> out_fired_id > prev_id_r)
    else $error("fired ids out of order within a run");

  // nothing comes out right after reset
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // queue is empty and ready after reset
  a_reset_in: assert property (@(posedge clk)
    !rst_n |=> in_ready)
    else $error("input not ready after reset");

endmodule

bind periodic_timer_table ptt_checker u_chk (.*);

`default_nettype wire

FILE: sim/tb_top.sv
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ptt_pkg::*;

  // op code 3 is unused by the block and must be ignored
  localparam logic [1:0] OP_RSVD = 2'd3;
  localparam int RANDOM_CMDS = 82;
  localparam int LONG_HOLD   = 400;
  localparam int DRAIN_LIMIT = 100000;

  typedef struct {
    logic [1:0]        op;
    logic [ID_W-1:0]   id;
    logic [TICK_W-1:0] period;
    logic [TICK_W-1:0] now;
  } timer_cmd_t;

  typedef struct {
    logic [ID_W-1:0] id;
    logic            last;
  } fire_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [1:0]        in_op = OP_SET;
  logic [ID_W-1:0]   in_timer_id = '0;
  logic [TICK_W-1:0] in_period = '0;
  logic [TICK_W-1:0] in_now = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [ID_W-1:0]   out_fired_id;
  logic              out_last_of_run;

  periodic_timer_table dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_op           (in_op),
    .in_timer_id     (in_timer_id),
    .in_period       (in_period),
    .in_now          (in_now),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_fired_id    (out_fired_id),
    .out_last_of_run (out_last_of_run)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  timer_cmd_t cmd_q[$];
  fire_t      due_q[$];
  int         err_cnt = 0;
  int         accepted_cnt = 0;
  int         hold_left = 0;

  // shadow copy of the timer table
  logic              armed_tbl [TIMER_COUNT];
  logic [TICK_W-1:0] period_tbl[TIMER_COUNT];
  logic [TICK_W-1:0] start_tbl [TIMER_COUNT];

  initial begin
    for (int i = 0; i < TIMER_COUNT; i++) begin
      armed_tbl[i]  = 1'b0;
      period_tbl[i] = '0;
      start_tbl[i]  = '0;
    end
  end

  // apply one accepted command to the shadow table and queue the ids it fires
  task automatic predict_fires(input timer_cmd_t c);
    logic [TIMER_COUNT-1:0] fire_mask;
    logic [TICK_W-1:0]      elapsed;
    int                     n_fire;
    int                     k;
    fire_t                  f;
    fire_mask = '0;
    n_fire = 0;
    k = 0;
    case (c.op)
      OP_SET: begin
        if (int'(c.id) < TIMER_COUNT) begin
          period_tbl[c.id] = c.period;
          start_tbl[c.id]  = c.now;
          armed_tbl[c.id]  = 1'b1;
        end
      end
      OP_KILL: begin
        if (int'(c.id) < TIMER_COUNT) armed_tbl[c.id] = 1'b0;
      end
      OP_UPDATE: begin
        for (int i = 0; i < TIMER_COUNT; i++) begin
          if (armed_tbl[i]) begin
            elapsed = c.now - start_tbl[i];
            if (period_tbl[i] <= elapsed) begin
              start_tbl[i] = start_tbl[i] + period_tbl[i];
              fire_mask[i] = 1'b1;
              n_fire++;
            end
          end
        end
        for (int i = 0; i < TIMER_COUNT; i++) begin
          if (fire_mask[i]) begin
            f.id   = ID_W'(i);
            f.last = (k == n_fire - 1);
            due_q.push_back(f);
            k++;
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic add_cmd(input logic [1:0] op, input logic [ID_W-1:0] id,
                         input logic [TICK_W-1:0] period, input logic [TICK_W-1:0] now);
    timer_cmd_t c;
    c.op = op;
    c.id = id;
    c.period = period;
    c.now = now;
    cmd_q.push_back(c);
  endtask

  // sender: bursts of random length with random gaps, no gaps while the output is held off
  timer_cmd_t cur_cmd;
  int         gap_left = 0;
  int         burst_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_fires(cur_cmd);
        accepted_cnt <= accepted_cnt + 1;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0 && hold_left == 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (cmd_q.size() > 0) begin
          cur_cmd = cmd_q.pop_front();
          in_op       <= cur_cmd.op;
          in_timer_id <= cur_cmd.id;
          in_period   <= cur_cmd.period;
          in_now      <= cur_cmd.now;
          in_valid    <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 10);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: stall mode picked at random from four, plus one long hold-off
  int  rx_cyc = 0;
  int  rx_mode = 0;
  bit  hold_done = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      rx_cyc <= rx_cyc + 1;
      if (rx_cyc % 50 == 0) rx_mode <= $urandom_range(0, 3);
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (!hold_done && accepted_cnt >= 40) begin
        hold_done <= 1'b1;
        hold_left <= LONG_HOLD;
        out_ready <= 1'b0;
      end else begin
        case (rx_mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 99) < 60);
          2: out_ready <= ((rx_cyc % 5) < 3);
          default: out_ready <= ((rx_cyc % 7) == 0);
        endcase
      end
    end
  end

  // result check against the oldest expected fire
  always @(posedge clk) begin : check_fires
    fire_t want;
    if (rst_n && out_valid && out_ready) begin
      if (due_q.size() == 0) begin
        if (err_cnt < 10)
          $display("unexpected result: fired_id=%0d last_of_run=%0b",
                   out_fired_id, out_last_of_run);
        err_cnt++;
      end else begin
        want = due_q.pop_front();
        if (out_fired_id !== want.id || out_last_of_run !== want.last) begin
          if (err_cnt < 10)
            $display("mismatch: expected id=%0d last=%0b, got id=%0d last=%0b",
                     want.id, want.last, out_fired_id, out_last_of_run);
          err_cnt++;
        end
      end
    end
  end

  // stimulus, reset and end of run
  initial begin : main_seq
    logic [TICK_W-1:0] tick;
    int                r;
    int                waited;

    // directed: reserved op, empty table, unarmed kill, zero period, max period, wrap
    add_cmd(OP_RSVD, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_cmd(OP_UPDATE, 4'd0, 32'h0, 32'h0);
    add_cmd(OP_KILL, 4'd5, 32'h0, 32'h0);
    add_cmd(OP_SET, 4'd0, 32'h0, 32'd100);
    add_cmd(OP_SET, 4'd15, 32'hFFFF_FFFF, 32'h0);
    add_cmd(OP_SET, 4'd7, 32'd10, 32'hFFFF_FFFA);
    add_cmd(OP_UPDATE, 4'd3, 32'h0, 32'd4);
    // re-arm an armed entry, then kill the zero period one
    add_cmd(OP_SET, 4'd7, 32'd3, 32'd4);
    add_cmd(OP_KILL, 4'd0, 32'h0, 32'h0);
    add_cmd(OP_UPDATE, 4'd0, 32'h0, 32'd7);
    add_cmd(OP_UPDATE, 4'd0, 32'h0, 32'hFFFF_FFFF);
    // every entry armed and due in one update
    for (int i = 0; i < TIMER_COUNT; i++)
      add_cmd(OP_SET, ID_W'(i), TICK_W'(i), 32'd1000);
    add_cmd(OP_UPDATE, 4'd0, 32'h0, 32'd1015);

    // random: mostly coherent set/kill/update traffic on an advancing tick
    tick = 32'd1100;
    for (int n = 0; n < RANDOM_CMDS; n++) begin
      r = $urandom_range(0, 99);
      if (r < 35) begin
        r = $urandom_range(0, 99);
        add_cmd(OP_SET, ID_W'($urandom_range(0, TIMER_COUNT - 1)),
                (r < 80) ? TICK_W'($urandom_range(0, 48)) :
                (r < 90) ? '0 : TICK_W'($urandom()),
                tick - TICK_W'($urandom_range(0, 8)));
      end else if (r < 45) begin
        add_cmd(OP_KILL, ID_W'($urandom_range(0, TIMER_COUNT - 1)),
                $urandom(), $urandom());
      end else if (r < 88) begin
        tick = tick + TICK_W'($urandom_range(0, 24));
        add_cmd(OP_UPDATE, ID_W'($urandom()), $urandom(), tick);
      end else if (r < 93) begin
        add_cmd(OP_RSVD, ID_W'($urandom()), $urandom(), $urandom());
      end else begin
        add_cmd(2'($urandom_range(0, 2)), ID_W'($urandom()), $urandom(), $urandom());
      end
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // wait for the sender to drain, then for every expected fire
    while (cmd_q.size() > 0 || in_valid) @(posedge clk);
    waited = 0;
    while (due_q.size() > 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (60) @(posedge clk);

    // anything still expected was never delivered
    if (due_q.size() > 0) begin
      if (err_cnt < 10)
        $display("missing results: %0d expected fires never arrived", due_q.size());
      err_cnt += due_q.size();
    end

    if (err_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // run time limit
  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

`default_nettype wire

FILE: files.f
hw/rtl/ptt_pkg.sv
hw/rtl/ptt_ram.sv
hw/rtl/ptt_front.sv
hw/rtl/ptt_back.sv
hw/rtl/periodic_timer_table.sv
hw/rtl/ptt_checker.sv
sim/tb_top.sv
